@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Overlapping implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

@@ hw/rtl/rqps_pkg.sv @@
// Package with types and constants for the ready queue scheduler.
`timescale 1ns / 1ps
`default_nettype none
package rqps_pkg;
  localparam int QUEUE_COUNT = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int DW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = QW + DW;
  localparam int MEM_DEPTH = QUEUE_COUNT * QUEUE_DEPTH;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SELECT = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_PRIO = 2'd1;
  localparam logic [1:0] POL_SJF = 2'd2;
  localparam logic [1:0] POL_SRT = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] job;
    logic [15:0] rem;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_DONE
  } state_t;
endpackage
`default_nettype wire

@@ hw/rtl/ready_queue_policy_scheduler.sv @@
// Top level of the ready queue scheduler with selectable policy.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Ready queue scheduler. QUEUE_COUNT queues of QUEUE_DEPTH entries share one
// entry memory with a single registered read port, and one sequencer walks
// that port and a single compare unit. An add, an unused op code or any item
// on an empty queue goes from S_READ straight to S_DONE. Select reads each
// entry of the queue once through the read port before it shows its result.
// Remove first scans for the id and then moves every later entry down one
// place, each move a read in S_SHIFT_RD and a write in S_SHIFT_WR; the worst
// case is a match on the first entry of a full queue. One item is in work at
// a time; in_stall stays high until its result has been taken, and the next
// item can be accepted in the cycle after that. The result sits in an output
// register and out_valid holds until out_stall is low. The policy register
// may only be written while the block is idle.
module ready_queue_policy_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_policy,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [2:0]  in_queue,
  input  wire logic [15:0] in_task_id,
  input  wire logic [7:0]  in_task_priority,
  input  wire logic [15:0] in_job_size,
  input  wire logic [15:0] in_remaining_size,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [15:0]      out_chosen_id
);
  localparam int QW = rqps_pkg::QW;
  localparam int DW = rqps_pkg::DW;
  localparam int CW = rqps_pkg::CW;
  localparam int AW = rqps_pkg::AW;

  rqps_pkg::entry_t mem [rqps_pkg::MEM_DEPTH];
  rqps_pkg::entry_t rd_data_r;
  logic [AW-1:0] rd_addr;
  logic rd_en;
  logic [AW-1:0] wr_addr;
  logic wr_en;
  rqps_pkg::entry_t wr_data;

  logic [CW-1:0] count_r [rqps_pkg::QUEUE_COUNT];
  logic [CW-1:0] count_nxt [rqps_pkg::QUEUE_COUNT];

  rqps_pkg::state_t state_r, state_nxt;
  logic [1:0] policy_r;
  logic [1:0] op_r, op_nxt;
  logic [QW-1:0] q_r, q_nxt;
  rqps_pkg::entry_t item_r, item_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] idx_r, idx_nxt;     // index of the entry on the read port
  rqps_pkg::entry_t best_r, best_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] status_r, status_nxt;
  logic [15:0] chosen_r, chosen_nxt;
  logic [QW-1:0] q_in;
  logic better;

  // Out-of-range queue indices fall back to queue 0.
  always_comb begin
    if (32'(in_queue) >= rqps_pkg::QUEUE_COUNT) q_in = '0;
    else q_in = QW'(in_queue);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // The shared compare unit: candidate on the read port against the best.
  always_comb begin
    case (policy_r)
      rqps_pkg::POL_PRIO: better = rd_data_r.prio > best_r.prio;
      rqps_pkg::POL_SJF:  better = rd_data_r.job < best_r.job;
      rqps_pkg::POL_SRT:  better = rd_data_r.rem < best_r.rem;
      default:            better = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rqps_pkg::S_IDLE;
      policy_r <= rqps_pkg::POL_FCFS;
      out_valid_r <= 1'b0;
      for (int i = 0; i < rqps_pkg::QUEUE_COUNT; i++) count_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) policy_r <= cfg_policy;
      for (int i = 0; i < rqps_pkg::QUEUE_COUNT; i++) count_r[i] <= count_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    q_r <= q_nxt;
    item_r <= item_nxt;
    n_r <= n_nxt;
    idx_r <= idx_nxt;
    best_r <= best_nxt;
    status_r <= status_nxt;
    chosen_r <= chosen_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    q_nxt = q_r;
    item_nxt = item_r;
    n_nxt = n_r;
    idx_nxt = idx_r;
    best_nxt = best_r;
    status_nxt = status_r;
    chosen_nxt = chosen_r;
    out_valid_nxt = out_valid_r;
    count_nxt = count_r;
    rd_en = 1'b0;
    rd_addr = {q_r, idx_r[DW-1:0]};
    wr_en = 1'b0;
    wr_addr = {q_r, idx_r[DW-1:0]};
    wr_data = item_r;
    in_stall = 1'b1;
    unique case (state_r)
      rqps_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op_nxt = in_op;
          q_nxt = q_in;
          item_nxt = '{in_task_id, in_task_priority, in_job_size, in_remaining_size};
          n_nxt = count_r[q_in];
          idx_nxt = '0;
          state_nxt = rqps_pkg::S_READ;
        end
      end
      rqps_pkg::S_READ: begin
        chosen_nxt = '0;
        status_nxt = rqps_pkg::ST_OK;
        state_nxt = rqps_pkg::S_DONE;
        case (op_r)
          rqps_pkg::OP_ADD: begin
            if (32'(n_r) >= rqps_pkg::QUEUE_DEPTH) begin
              status_nxt = rqps_pkg::ST_FULL;
            end else begin
              wr_en = 1'b1;
              wr_addr = {q_r, n_r[DW-1:0]};
              count_nxt[q_r] = n_r + CW'(1);
            end
          end
          rqps_pkg::OP_REMOVE: begin
            status_nxt = rqps_pkg::ST_NOT_FOUND;
            if (n_r != '0) begin
              rd_en = 1'b1;
              state_nxt = rqps_pkg::S_SCAN;
            end
          end
          rqps_pkg::OP_SELECT: begin
            status_nxt = rqps_pkg::ST_EMPTY;
            if (n_r != '0) begin
              rd_en = 1'b1;
              state_nxt = rqps_pkg::S_SCAN;
            end
          end
          default: ;
        endcase
      end
      rqps_pkg::S_SCAN: begin
        // rd_data_r holds entry idx_r.
        if (op_r == rqps_pkg::OP_SELECT) begin
          if (idx_r == '0 || better) best_nxt = rd_data_r;
          if (idx_r + CW'(1) >= n_r) begin
            status_nxt = rqps_pkg::ST_OK;
            chosen_nxt = (idx_r == '0 || better) ? rd_data_r.id : best_r.id;
            state_nxt = rqps_pkg::S_DONE;
          end else begin
            idx_nxt = idx_r + CW'(1);
            rd_en = 1'b1;
            rd_addr = {q_r, idx_nxt[DW-1:0]};
          end
        end else if (rd_data_r.id == item_r.id) begin
          status_nxt = rqps_pkg::ST_OK;
          count_nxt[q_r] = n_r - CW'(1);
          state_nxt = rqps_pkg::S_SHIFT_RD;
        end else if (idx_r + CW'(1) >= n_r) begin
          state_nxt = rqps_pkg::S_DONE;
        end else begin
          idx_nxt = idx_r + CW'(1);
          rd_en = 1'b1;
          rd_addr = {q_r, idx_nxt[DW-1:0]};
        end
      end
      rqps_pkg::S_SHIFT_RD: begin
        // Move entry idx+1 down to idx while one remains.
        if (idx_r + CW'(1) >= n_r) begin
          state_nxt = rqps_pkg::S_DONE;
        end else begin
          rd_en = 1'b1;
          rd_addr = {q_r, DW'(idx_r + CW'(1))};
          state_nxt = rqps_pkg::S_SHIFT_WR;
        end
      end
      rqps_pkg::S_SHIFT_WR: begin
        wr_en = 1'b1;
        wr_data = rd_data_r;
        idx_nxt = idx_r + CW'(1);
        state_nxt = rqps_pkg::S_SHIFT_RD;
      end
      rqps_pkg::S_DONE: begin
        out_valid_nxt = 1'b1;
        if (out_valid_r && !out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt = rqps_pkg::S_IDLE;
        end
      end
      default: state_nxt = rqps_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_chosen_id = chosen_r;

  // A result is only shown once the sequencer has finished its item.
  `CHK_IMPL(a_out_in_done, clk, rst_n, out_valid, state_r == rqps_pkg::S_DONE)
  // The input side is closed while an item is in work.
  `CHK_IMPL(a_busy_stall, clk, rst_n, state_r != rqps_pkg::S_IDLE, in_stall)
  // A taken result returns the sequencer to idle.
  `CHK_NEXT(a_take_idle, clk, rst_n, out_valid && !out_stall,
            state_r == rqps_pkg::S_IDLE && !out_valid)
endmodule
`default_nettype wire
